// ===== hdl/mptd_pkg.sv =====
package mptd_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CAP_W      = 16;
	localparam int OVF_W      = 2;
	localparam int REG_W      = 18;
	localparam int KIND_W     = 3;
	localparam int CHAR_W     = 7;
	localparam int CNT_W      = 3;
	localparam int REC_DEPTH  = 5;
	localparam int NUM_CODES  = 36;
	localparam int QDEPTH     = 2;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam int SPAN_W    = TIMER_BITS + OVF_W;
	localparam int ELAPSED_W = ((SPAN_W > REG_W) ? SPAN_W : REG_W) + 1;

	localparam logic [REG_W-1:0] DOT_MIN_RST    = REG_W'(1875);
	localparam logic [REG_W-1:0] DASH_MIN_RST   = REG_W'(12500);
	localparam logic [REG_W-1:0] DASH_MAX_RST   = REG_W'(25000);
	localparam logic [REG_W-1:0] LETTER_GAP_RST = REG_W'(25000);

	typedef enum logic [1:0] {
		REG_DOT_MIN    = 2'd0,
		REG_DASH_MIN   = 2'd1,
		REG_DASH_MAX   = 2'd2,
		REG_LETTER_GAP = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_DOT  = 2'd1,
		OP_DASH = 2'd2,
		OP_GAP  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		EV_NONE    = 3'd0,
		EV_DOT     = 3'd1,
		EV_DASH    = 3'd2,
		EV_CHAR    = 3'd3,
		EV_UNKNOWN = 3'd4,
		EV_DROP    = 3'd5
	} event_t;

	typedef struct packed {
		logic [REG_W-1:0] dot_min;
		logic [REG_W-1:0] dash_min;
		logic [REG_W-1:0] dash_max;
		logic [REG_W-1:0] letter_gap;
	} thresh_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_beat_t;

	typedef struct packed {
		logic [CNT_W-1:0]     len;
		logic [REC_DEPTH-1:0] bits;
		logic [CHAR_W-1:0]    ascii;
	} code_t;

	// dash = 1, first symbol in the highest used bit
	localparam code_t CODE_TABLE [NUM_CODES] = '{
		'{3'd2, 5'd1,  7'h41}, '{3'd4, 5'd8,  7'h42}, '{3'd4, 5'd10, 7'h43},
		'{3'd3, 5'd4,  7'h44}, '{3'd1, 5'd0,  7'h45}, '{3'd4, 5'd2,  7'h46},
		'{3'd3, 5'd6,  7'h47}, '{3'd4, 5'd0,  7'h48}, '{3'd2, 5'd0,  7'h49},
		'{3'd4, 5'd7,  7'h4A}, '{3'd3, 5'd5,  7'h4B}, '{3'd4, 5'd4,  7'h4C},
		'{3'd2, 5'd3,  7'h4D}, '{3'd2, 5'd2,  7'h4E}, '{3'd3, 5'd7,  7'h4F},
		'{3'd4, 5'd6,  7'h50}, '{3'd4, 5'd13, 7'h51}, '{3'd3, 5'd2,  7'h52},
		'{3'd3, 5'd0,  7'h53}, '{3'd1, 5'd1,  7'h54}, '{3'd3, 5'd1,  7'h55},
		'{3'd4, 5'd1,  7'h56}, '{3'd3, 5'd3,  7'h57}, '{3'd4, 5'd9,  7'h58},
		'{3'd4, 5'd11, 7'h59}, '{3'd4, 5'd12, 7'h5A},
		'{3'd5, 5'd31, 7'h30}, '{3'd5, 5'd15, 7'h31}, '{3'd5, 5'd7,  7'h32},
		'{3'd5, 5'd3,  7'h33}, '{3'd5, 5'd1,  7'h34}, '{3'd5, 5'd0,  7'h35},
		'{3'd5, 5'd16, 7'h36}, '{3'd5, 5'd24, 7'h37}, '{3'd5, 5'd28, 7'h38},
		'{3'd5, 5'd30, 7'h39}
	};

	// zero when the pattern matches no character
	function automatic logic [CHAR_W-1:0] lookup_char(
		input logic [CNT_W-1:0]     len,
		input logic [REC_DEPTH-1:0] bits
	);
		logic [CHAR_W-1:0] res;
		res = '0;
		for (int i = 0; i < NUM_CODES; i++) begin
			if (CODE_TABLE[i].len == len && CODE_TABLE[i].bits == bits) begin
				res = CODE_TABLE[i].ascii;
			end
		end
		return res;
	endfunction

endpackage

// ===== hdl/mptd_if.sv =====
interface mptd_in_if;
	logic                          valid;
	logic                          ready;
	logic                          edge_rising;
	logic [mptd_pkg::CAP_W-1:0]    capture_time;
	logic [mptd_pkg::OVF_W-1:0]    overflow_count;

	modport source (output valid, edge_rising, capture_time, overflow_count, input ready);
	modport sink (input valid, edge_rising, capture_time, overflow_count, output ready);
endinterface

interface mptd_out_if;
	logic                          valid;
	logic                          ready;
	logic [mptd_pkg::KIND_W-1:0]   event_kind;
	logic [mptd_pkg::CHAR_W-1:0]   char_code;
	logic [mptd_pkg::CNT_W-1:0]    symbols_held;

	modport source (output valid, event_kind, char_code, symbols_held, input ready);
	modport sink (input valid, event_kind, char_code, symbols_held, output ready);
endinterface

// ===== hdl/mptd_front.sv =====
module mptd_front (
	input  logic                clk,
	input  logic                arst_n,
	mptd_in_if.sink             in_ch,
	input  mptd_pkg::thresh_t   thresh,
	input  logic                q_full,
	output mptd_pkg::op_beat_t  push
);
	import mptd_pkg::*;

	logic [TIMER_BITS-1:0]       last_q;
	logic [TIMER_BITS-1:0]       cap;
	logic signed [ELAPSED_W-1:0] elapsed;
	logic signed [ELAPSED_W-1:0] t_dot_min;
	logic signed [ELAPSED_W-1:0] t_dash_min;
	logic signed [ELAPSED_W-1:0] t_dash_max;
	logic signed [ELAPSED_W-1:0] t_gap;
	logic                        accept;
	op_t                         op;

	assign cap        = in_ch.capture_time[TIMER_BITS-1:0];
	assign elapsed    = $signed(ELAPSED_W'({in_ch.overflow_count, cap}))
	                  - $signed(ELAPSED_W'(last_q));
	assign t_dot_min  = $signed(ELAPSED_W'(thresh.dot_min));
	assign t_dash_min = $signed(ELAPSED_W'(thresh.dash_min));
	assign t_dash_max = $signed(ELAPSED_W'(thresh.dash_max));
	assign t_gap      = $signed(ELAPSED_W'(thresh.letter_gap));

	always_comb begin
		op = OP_NONE;
		if (in_ch.edge_rising) begin
			if (elapsed > t_dot_min && elapsed < t_dash_min) begin
				op = OP_DOT;
			end else if (elapsed > t_dash_min && elapsed < t_dash_max) begin
				op = OP_DASH;
			end
		end else if (elapsed > t_gap) begin
			op = OP_GAP;
		end
	end

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && !q_full;
	assign push.valid  = accept;
	assign push.op     = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (accept) begin
			last_q <= cap;
		end
	end
endmodule

// ===== hdl/mptd_queue.sv =====
module mptd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mptd_pkg::op_beat_t  push,
	output logic                full,
	input  logic                pop,
	output mptd_pkg::op_beat_t  head
);
	import mptd_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	op_t               slot_q [QDEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == CNT_QW'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.op    = slot_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_q] <= push.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (do_pop && !push.valid) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end
endmodule

// ===== hdl/mptd_back.sv =====
module mptd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mptd_pkg::op_beat_t  head,
	output logic                pop,
	mptd_out_if.source          out_ch
);
	import mptd_pkg::*;

	logic [REC_DEPTH-1:0] pat_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	event_t               kind_q;
	logic [CHAR_W-1:0]    char_q;

	logic [REC_DEPTH-1:0] pat_d;
	logic [CNT_W-1:0]     cnt_d;
	event_t               kind_d;
	logic [CHAR_W-1:0]    char_d;
	logic [CHAR_W-1:0]    found;

	assign pop   = head.valid && (!out_valid_q || out_ch.ready);
	assign found = lookup_char(cnt_q, pat_q);

	always_comb begin
		pat_d  = pat_q;
		cnt_d  = cnt_q;
		kind_d = EV_NONE;
		char_d = '0;
		case (head.op)
			OP_DOT, OP_DASH: begin
				if (cnt_q < CNT_W'(REC_DEPTH)) begin
					pat_d  = {pat_q[REC_DEPTH-2:0], (head.op == OP_DASH)};
					cnt_d  = cnt_q + CNT_W'(1);
					kind_d = (head.op == OP_DASH) ? EV_DASH : EV_DOT;
				end else begin
					kind_d = EV_DROP;
				end
			end
			OP_GAP: begin
				pat_d = '0;
				cnt_d = '0;
				if (found != '0) begin
					kind_d = EV_CHAR;
					char_d = found;
				end else begin
					kind_d = EV_UNKNOWN;
				end
			end
			default: begin
				kind_d = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pat_q       <= pat_d;
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= kind_d;
			char_q <= char_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_kind   = kind_q;
	assign out_ch.char_code    = char_q;
	assign out_ch.symbols_held = cnt_q;
endmodule

// ===== hdl/morse_pulse_timing_decoder_top.sv =====
// channel | dir | beat payload
// in_ch   | in  | edge_rising, capture_time, overflow_count
// out_ch  | out | event_kind, char_code, symbols_held
// apb     | in  | 4 threshold registers at 0x0, 0x4, 0x8, 0xc
//
// one edge per cycle while the op queue is not full; a result goes through the queue slot and the output register
// a two-beat op queue sits between the edge classifier and the symbol record
// in_ch.ready drops only while that queue is full, out_ch stalls fill it
// reset loads default thresholds and clears the record and last edge time
module morse_pulse_timing_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	mptd_in_if.sink                       in_ch,
	mptd_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mptd_pkg::APB_AW-1:0]   paddr,
	input  logic [mptd_pkg::APB_DW-1:0]   pwdata,
	output logic [mptd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import mptd_pkg::*;

	thresh_t  thresh_q;
	op_beat_t push;
	op_beat_t head;
	logic     q_full;
	logic     pop;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.dot_min    <= DOT_MIN_RST;
			thresh_q.dash_min   <= DASH_MIN_RST;
			thresh_q.dash_max   <= DASH_MAX_RST;
			thresh_q.letter_gap <= LETTER_GAP_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DOT_MIN:    thresh_q.dot_min    <= pwdata[REG_W-1:0];
				REG_DASH_MIN:   thresh_q.dash_min   <= pwdata[REG_W-1:0];
				REG_DASH_MAX:   thresh_q.dash_max   <= pwdata[REG_W-1:0];
				REG_LETTER_GAP: thresh_q.letter_gap <= pwdata[REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DOT_MIN:    prdata = APB_DW'(thresh_q.dot_min);
			REG_DASH_MIN:   prdata = APB_DW'(thresh_q.dash_min);
			REG_DASH_MAX:   prdata = APB_DW'(thresh_q.dash_max);
			REG_LETTER_GAP: prdata = APB_DW'(thresh_q.letter_gap);
			default:        prdata = '0;
		endcase
	end

	mptd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.thresh (thresh_q),
		.q_full (q_full),
		.push   (push)
	);

	mptd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	mptd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.symbols_held <= CNT_W'(REC_DEPTH))
		else $error("symbols_held out of range");

	a_char_only_on_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.event_kind != EV_CHAR) |-> out_ch.char_code == '0)
		else $error("char_code set without a decoded character");

	a_record_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.event_kind == EV_CHAR || out_ch.event_kind == EV_UNKNOWN))
		|-> out_ch.symbols_held == '0)
		else $error("record not cleared at letter gap");

	a_symbol_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.event_kind == EV_DOT || out_ch.event_kind == EV_DASH
		|| out_ch.event_kind == EV_DROP)) |-> out_ch.symbols_held != '0)
		else $error("symbol event with empty record");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push.valid)
		else $error("op queue overrun");
endmodule
